/* design/kvd_pkg.sv */
package kvd_pkg;

  // Parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_KLEN    = 3'd1;
  localparam logic [2:0] PH_KEY     = 3'd2;
  localparam logic [2:0] PH_VLEN    = 3'd3;
  localparam logic [2:0] PH_VAL     = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  // Byte kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_KLEN    = 3'd1;
  localparam logic [2:0] KIND_KEY     = 3'd2;
  localparam logic [2:0] KIND_VLEN    = 3'd3;
  localparam logic [2:0] KIND_VAL     = 3'd4;
  localparam logic [2:0] KIND_DISCARD = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MODIFIER = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;

  // Header byte positions
  localparam logic [1:0] HDR_MOD   = 2'd0;
  localparam logic [1:0] HDR_SIZE0 = 2'd1;
  localparam logic [1:0] HDR_SIZE1 = 2'd2;
  localparam logic [1:0] HDR_RSVD  = 2'd3;

  // Reset value of the accepted modifier
  localparam logic [7:0] MODIFIER_RESET = 8'd0;

  // Output packing widths
  localparam int TDATA_W = 64;
  localparam int TUSER_W = 4;

  // One result item
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_kind;
    logic [15:0] key_length;
    logic [15:0] value_length;
    logic [15:0] block_length;
    logic [1:0]  status;
    logic        pair_done;
    logic        block_done;
  } res_t;

endpackage

/* design/key_value_packet_deframer_top.sv */
// Key/value packet deframer. Takes one stream byte per item and returns one
// result item for each: the byte echoed with its kind, the current key, value
// and block lengths and a status, with pair_done and block_done marks. A
// packet is a 4-byte header (modifier, little-endian block size, reserved)
// followed by a block of length-prefixed key/value pairs; a bad modifier or
// a length that is cut off or overruns the block discards the rest of the
// block. One item per clock cycle is sustained while the result side is
// ready: the parser state register is updated once per byte by a single
// decode pass between the input and result registers. An accepted item
// passes the input, then the result register; back-pressure on the result
// side stalls the input. The user must write the accepted modifier on the
// cfg port (always ready) only while the block is idle; nothing enforces it.
module key_value_packet_deframer_top import kvd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,      // accepted_modifier[7:0]
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // data_byte[7:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // byte_value[7:0], key_length[23:8], value_length[39:24],
  // block_length[55:40], status[57:56], zero[63:58]
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [TUSER_W-1:0] m_axis_tuser,  // byte_kind[2:0], pair_done[3]
  output logic               m_axis_tlast   // block_done
);

  logic [7:0] acc_mod;
  logic       in_vld;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;
  res_t       res;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_mod <= MODIFIER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      acc_mod <= cfg_data;
    end
  end

  // Input register
  assign s_axis_tready = !in_vld || advance;
  assign step          = in_vld && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  kvd_core u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .data_byte         (in_byte),
    .accepted_modifier (acc_mod),
    .res               (res)
  );

  kvd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .in_valid      (in_vld),
    .res           (res),
    .advance       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* design/kvd_core.sv */
module kvd_core import kvd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic [7:0] accepted_modifier,
  output res_t       res
);

  logic [2:0]  phase, phase_next;
  logic [1:0]  hdr_idx, hdr_idx_next;
  logic [15:0] blk_rem, blk_rem_next;
  logic [15:0] fld_rem, fld_rem_next;
  logic [7:0]  low_latch, low_latch_next;
  logic        mod_bad, mod_bad_next;
  logic [15:0] hk, hk_next;
  logic [15:0] hv, hv_next;
  logic [15:0] hb, hb_next;

  // Per-byte decode and state update
  always_comb begin
    logic [15:0] br;
    logic [15:0] fr;
    logic [15:0] len;
    logic        is_key;
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    blk_rem_next   = blk_rem;
    fld_rem_next   = fld_rem;
    low_latch_next = low_latch;
    mod_bad_next   = mod_bad;
    hk_next        = hk;
    hv_next        = hv;
    hb_next        = hb;
    res.byte_value = data_byte;
    res.byte_kind  = KIND_HEADER;
    res.status     = ST_OK;
    res.pair_done  = 1'b0;
    res.block_done = 1'b0;
    br     = blk_rem - 16'd1;
    fr     = fld_rem - 16'd1;
    len    = {data_byte, low_latch};
    is_key = 1'b0;

    if (phase == PH_HEADER || phase > PH_DISCARD) begin
      phase_next = PH_HEADER;
      case (hdr_idx)
        HDR_MOD: begin
          mod_bad_next = (data_byte != accepted_modifier);
          hb_next      = '0;
          hk_next      = '0;
          hv_next      = '0;
          hdr_idx_next = HDR_SIZE0;
        end
        HDR_SIZE0: begin
          low_latch_next = data_byte;
          hdr_idx_next   = HDR_SIZE1;
        end
        HDR_SIZE1: begin
          hb_next      = len;
          hdr_idx_next = HDR_RSVD;
        end
        default: begin
          blk_rem_next = hb;
          hdr_idx_next = HDR_MOD;
          if (hb == '0) begin
            res.block_done = 1'b1;
            phase_next     = PH_HEADER;
          end else begin
            phase_next = mod_bad ? PH_DISCARD : PH_KLEN;
          end
        end
      endcase
      if (mod_bad_next) res.status = ST_MODIFIER;
    end else begin
      blk_rem_next = br;
      if (phase == PH_KLEN || phase == PH_VLEN) begin
        // Length field bytes
        is_key        = (phase == PH_KLEN);
        res.byte_kind = is_key ? KIND_KLEN : KIND_VLEN;
        if (hdr_idx == '0) begin
          if (is_key) begin
            hk_next = '0;
            hv_next = '0;
          end
          if (br == '0) begin
            res.status     = ST_OVERRUN;
            res.block_done = 1'b1;
            phase_next     = PH_HEADER;
            hdr_idx_next   = HDR_MOD;
          end else begin
            low_latch_next = data_byte;
            hdr_idx_next   = 2'd1;
          end
        end else begin
          hdr_idx_next = '0;
          if (is_key) hk_next = len;
          else        hv_next = len;
          if (len > br) begin
            res.status = ST_OVERRUN;
            if (br == '0) begin
              res.block_done = 1'b1;
              phase_next     = PH_HEADER;
            end else begin
              phase_next = PH_DISCARD;
            end
          end else if (len == '0) begin
            if (is_key) begin
              if (br == '0) begin
                res.status     = ST_OVERRUN;
                res.block_done = 1'b1;
                phase_next     = PH_HEADER;
              end else begin
                phase_next = PH_VLEN;
              end
            end else begin
              res.pair_done = 1'b1;
              if (br == '0) begin
                res.block_done = 1'b1;
                phase_next     = PH_HEADER;
              end else begin
                phase_next = PH_KLEN;
              end
            end
          end else begin
            fld_rem_next = len;
            phase_next   = is_key ? PH_KEY : PH_VAL;
          end
        end
      end else if (phase == PH_KEY || phase == PH_VAL) begin
        // Key and value payload bytes
        is_key        = (phase == PH_KEY);
        res.byte_kind = is_key ? KIND_KEY : KIND_VAL;
        fld_rem_next  = fr;
        if (fr == '0) begin
          hdr_idx_next = '0;
          if (is_key) begin
            if (br == '0) begin
              res.status     = ST_OVERRUN;
              res.block_done = 1'b1;
              phase_next     = PH_HEADER;
            end else begin
              phase_next = PH_VLEN;
            end
          end else begin
            res.pair_done = 1'b1;
            if (br == '0) begin
              res.block_done = 1'b1;
              phase_next     = PH_HEADER;
            end else begin
              phase_next = PH_KLEN;
            end
          end
        end
      end else begin
        // Rest of a rejected block
        res.byte_kind = KIND_DISCARD;
        res.status    = mod_bad ? ST_MODIFIER : ST_OVERRUN;
        if (br == '0) begin
          res.block_done = 1'b1;
          phase_next     = PH_HEADER;
          hdr_idx_next   = HDR_MOD;
        end
      end
    end

    res.key_length   = hk_next;
    res.value_length = hv_next;
    res.block_length = hb_next;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hdr_idx   <= HDR_MOD;
      blk_rem   <= '0;
      fld_rem   <= '0;
      low_latch <= '0;
      mod_bad   <= 1'b0;
      hk        <= '0;
      hv        <= '0;
      hb        <= '0;
    end else if (step) begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      blk_rem   <= blk_rem_next;
      fld_rem   <= fld_rem_next;
      low_latch <= low_latch_next;
      mod_bad   <= mod_bad_next;
      hk        <= hk_next;
      hv        <= hv_next;
      hb        <= hb_next;
    end
  end

endmodule

/* design/kvd_out_reg.sv */
module kvd_out_reg import kvd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               in_valid,
  input  res_t               res,
  output logic               advance,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [TUSER_W-1:0] m_axis_tuser,
  output logic               m_axis_tlast
);

  logic out_vld;
  res_t out_res;

  // Register empties or is being drained
  assign advance = !out_vld || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  // Pack result fields
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'd0, out_res.status, out_res.block_length,
                          out_res.value_length, out_res.key_length,
                          out_res.byte_value};
  assign m_axis_tuser  = {out_res.pair_done, out_res.byte_kind};
  assign m_axis_tlast  = out_res.block_done;

endmodule

/* bench/key_value_packet_deframer_top_test.sv */
module key_value_packet_deframer_top_test;
  import kvd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEMS_PER_SETTING = 60;
  localparam int PRINT_CAP = 40;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [7:0]          cfg_data;      // accepted_modifier[7:0]
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;  // data_byte[7:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // byte_value[7:0], key_length[23:8], value_length[39:24],
  // block_length[55:40], status[57:56], zero[63:58]
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [TUSER_W-1:0]  m_axis_tuser;  // byte_kind[2:0], pair_done[3]
  logic                m_axis_tlast;  // block_done

  key_value_packet_deframer_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Directed stimulus row; want is only used where typed is set
  typedef struct {
    logic [7:0] data_byte;
    bit         typed;
    res_t       want;
  } dir_row_t;

  // Parser mirror
  logic [7:0]  want_modifier;
  logic [2:0]  prs_phase;
  logic [1:0]  hdr_pos;
  logic        len_hi_next;
  logic [15:0] blk_left;
  logic [15:0] fld_left;
  logic [7:0]  len_lo;
  logic        mod_rejected;
  logic [15:0] cur_key_len;
  logic [15:0] cur_val_len;
  logic [15:0] cur_blk_len;

  res_t        results_due[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  pkt[$];
  int          mismatches;
  int          results_seen;
  int          cycles;
  int          items_sent;

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("key_value_packet_deframer_top_test NOT OK");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_seen, what, got, want);
  endtask

  function automatic void restart_header();
    prs_phase   = PH_HEADER;
    hdr_pos     = HDR_MOD;
    len_hi_next = 1'b0;
  endfunction

  function automatic void clear_parser();
    restart_header();
    blk_left     = '0;
    fld_left     = '0;
    len_lo       = '0;
    mod_rejected = 1'b0;
    cur_key_len  = '0;
    cur_val_len  = '0;
    cur_blk_len  = '0;
  endfunction

  // Expected result for one stream byte; advances the mirror
  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t        r;
    logic [15:0] len;
    logic        is_key;
    r            = '0;
    r.byte_value = b;
    r.byte_kind  = KIND_HEADER;
    r.status     = ST_OK;
    if (prs_phase == PH_HEADER) begin
      case (hdr_pos)
        HDR_MOD: begin
          mod_rejected = (b != want_modifier);
          cur_blk_len  = '0;
          cur_key_len  = '0;
          cur_val_len  = '0;
          hdr_pos      = HDR_SIZE0;
        end
        HDR_SIZE0: begin
          len_lo  = b;
          hdr_pos = HDR_SIZE1;
        end
        HDR_SIZE1: begin
          cur_blk_len = {b, len_lo};
          hdr_pos     = HDR_RSVD;
        end
        default: begin
          blk_left = cur_blk_len;
          hdr_pos  = HDR_MOD;
          if (blk_left == 0) begin
            r.block_done = 1'b1;
            restart_header();
          end else begin
            prs_phase = mod_rejected ? PH_DISCARD : PH_KLEN;
          end
        end
      endcase
      if (mod_rejected) r.status = ST_MODIFIER;
    end else begin
      blk_left = blk_left - 16'd1;
      if (prs_phase == PH_KLEN || prs_phase == PH_VLEN) begin
        is_key      = (prs_phase == PH_KLEN);
        r.byte_kind = is_key ? KIND_KLEN : KIND_VLEN;
        if (!len_hi_next) begin
          if (is_key) begin
            cur_key_len = '0;
            cur_val_len = '0;
          end
          // a length cut in half by the end of the block
          if (blk_left == 0) begin
            r.status     = ST_OVERRUN;
            r.block_done = 1'b1;
            restart_header();
          end else begin
            len_lo      = b;
            len_hi_next = 1'b1;
          end
        end else begin
          len         = {b, len_lo};
          len_hi_next = 1'b0;
          if (is_key) cur_key_len = len;
          else cur_val_len = len;
          if (len > blk_left) begin
            r.status = ST_OVERRUN;
            if (blk_left == 0) begin
              r.block_done = 1'b1;
              restart_header();
            end else begin
              prs_phase = PH_DISCARD;
            end
          end else if (len == 0) begin
            if (is_key) begin
              // empty key at block end leaves no room for a value length
              if (blk_left == 0) begin
                r.status     = ST_OVERRUN;
                r.block_done = 1'b1;
                restart_header();
              end else begin
                prs_phase = PH_VLEN;
              end
            end else begin
              r.pair_done = 1'b1;
              if (blk_left == 0) begin
                r.block_done = 1'b1;
                restart_header();
              end else begin
                prs_phase = PH_KLEN;
              end
            end
          end else begin
            fld_left  = len;
            prs_phase = is_key ? PH_KEY : PH_VAL;
          end
        end
      end else if (prs_phase == PH_KEY || prs_phase == PH_VAL) begin
        is_key      = (prs_phase == PH_KEY);
        r.byte_kind = is_key ? KIND_KEY : KIND_VAL;
        fld_left    = fld_left - 16'd1;
        if (fld_left == 0) begin
          if (is_key) begin
            if (blk_left == 0) begin
              r.status     = ST_OVERRUN;
              r.block_done = 1'b1;
              restart_header();
            end else begin
              len_hi_next = 1'b0;
              prs_phase   = PH_VLEN;
            end
          end else begin
            r.pair_done = 1'b1;
            if (blk_left == 0) begin
              r.block_done = 1'b1;
              restart_header();
            end else begin
              len_hi_next = 1'b0;
              prs_phase   = PH_KLEN;
            end
          end
        end
      end else begin
        r.byte_kind = KIND_DISCARD;
        r.status    = mod_rejected ? ST_MODIFIER : ST_OVERRUN;
        if (blk_left == 0) begin
          r.block_done = 1'b1;
          restart_header();
        end
      end
    end
    r.key_length   = cur_key_len;
    r.value_length = cur_val_len;
    r.block_length = cur_blk_len;
    return r;
  endfunction

  // Idle gap length: mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int field_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    if (r < 80) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  function automatic dir_row_t open_row(input logic [7:0] b);
    dir_row_t d;
    d.data_byte = b;
    d.typed     = 1'b0;
    d.want      = '0;
    return d;
  endfunction

  // Typed rows all have zero key/value lengths and no pair_done
  function automatic dir_row_t typed_row(input logic [7:0] b, input logic [2:0] kind,
                                         input logic [15:0] blk, input logic [1:0] st,
                                         input logic bd);
    dir_row_t d;
    d                   = open_row(b);
    d.typed             = 1'b1;
    d.want.byte_value   = b;
    d.want.byte_kind    = kind;
    d.want.block_length = blk;
    d.want.status       = st;
    d.want.block_done   = bd;
    return d;
  endfunction

  // Offer one byte after a random gap; record the expectation on accept
  task automatic send_item(input logic [7:0] b, input res_t want, input bit calm);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    results_due.insert(results_due.size(), want);
    items_sent++;
  endtask

  task automatic write_modifier(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    want_modifier = v;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed packets, some truncated, padded, noisy or long
  task automatic make_packet();
    int         r;
    int         npairs;
    int         klen;
    int         vlen;
    int         keep;
    logic [7:0] mod;
    logic [15:0] bl;
    logic [7:0] body[$];
    r = $urandom_range(0, 99);
    if (r < 3) begin
      repeat ($urandom_range(256, 300)) body.insert(body.size(), 8'($urandom_range(0, 255)));
    end else if (r < 12) begin
      repeat ($urandom_range(0, 12)) body.insert(body.size(), 8'($urandom_range(0, 255)));
    end else begin
      npairs = $urandom_range(0, 4);
      repeat (npairs) begin
        klen = field_len();
        vlen = field_len();
        body.insert(body.size(), klen[7:0]);
        body.insert(body.size(), klen[15:8]);
        repeat (klen) body.insert(body.size(), 8'($urandom_range(0, 255)));
        body.insert(body.size(), vlen[7:0]);
        body.insert(body.size(), vlen[15:8]);
        repeat (vlen) body.insert(body.size(), 8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      if (r < 15 && body.size() > 0) begin
        keep = $urandom_range(0, body.size() - 1);
        while (body.size() > keep) void'(body.pop_back());
      end else if (r < 25) begin
        repeat ($urandom_range(1, 4)) body.insert(body.size(), 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 99) < 85) mod = want_modifier;
    else mod = want_modifier ^ 8'($urandom_range(1, 255));
    bl = 16'(body.size());
    pkt.delete();
    pkt.insert(pkt.size(), mod);
    pkt.insert(pkt.size(), bl[7:0]);
    pkt.insert(pkt.size(), bl[15:8]);
    pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
    foreach (body[i]) pkt.insert(pkt.size(), body[i]);
  endtask

  // Result side: random back-pressure and field-by-field check
  initial begin : result_side
    int         hold;
    bit         calm;
    bit         rdy;
    res_t       want;
    logic [7:0] got_kind;
    hold          = 0;
    calm          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          note_mismatch("result with none expected", 16'(m_axis_tdata[7:0]), 16'd0);
        end else begin
          want     = results_due.pop_front();
          got_kind = 8'(m_axis_tuser[2:0]);
          if (m_axis_tdata[7:0] !== want.byte_value)
            note_mismatch("byte_value", 16'(m_axis_tdata[7:0]), 16'(want.byte_value));
          if (m_axis_tuser[2:0] !== want.byte_kind)
            note_mismatch("byte_kind", 16'(got_kind), 16'(want.byte_kind));
          if (m_axis_tdata[23:8] !== want.key_length)
            note_mismatch("key_length", m_axis_tdata[23:8], want.key_length);
          if (m_axis_tdata[39:24] !== want.value_length)
            note_mismatch("value_length", m_axis_tdata[39:24], want.value_length);
          if (m_axis_tdata[55:40] !== want.block_length)
            note_mismatch("block_length", m_axis_tdata[55:40], want.block_length);
          if (m_axis_tdata[57:56] !== want.status)
            note_mismatch("status", 16'(m_axis_tdata[57:56]), 16'(want.status));
          if (m_axis_tdata[63:58] !== 6'd0)
            note_mismatch("tdata padding", 16'(m_axis_tdata[63:58]), 16'd0);
          if (m_axis_tuser[3] !== want.pair_done)
            note_mismatch("pair_done", 16'(m_axis_tuser[3]), 16'(want.pair_done));
          if (m_axis_tlast !== want.block_done)
            note_mismatch("block_done", 16'(m_axis_tlast), 16'(want.block_done));
        end
      end
      if (hold == 0) begin
        if ($urandom_range(0, 19) == 0) calm = ~calm;
        if (calm || $urandom_range(0, 99) < 60) begin
          rdy  = 1'b1;
          hold = $urandom_range(1, 8);
        end else begin
          rdy  = 1'b0;
          hold = pick_gap(1'b0) + 1;
        end
        m_axis_tready <= rdy;
      end
      hold--;
    end
  end

  // Stimulus
  initial begin : stimulus
    res_t       want;
    bit         calm;
    int         target;
    logic [7:0] settings[4];
    mismatches    = 0;
    results_seen  = 0;
    items_sent    = 0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    want_modifier = MODIFIER_RESET;
    clear_parser();

    // empty block with the reset modifier
    dir_rows.insert(dir_rows.size(), typed_row(8'h00, KIND_HEADER, 16'd0, ST_OK, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'h00, KIND_HEADER, 16'd0, ST_OK, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'h00, KIND_HEADER, 16'd0, ST_OK, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'h00, KIND_HEADER, 16'd0, ST_OK, 1'b1));
    // unsupported modifier, two-byte block discarded
    dir_rows.insert(dir_rows.size(), typed_row(8'hFF, KIND_HEADER, 16'd0, ST_MODIFIER, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'h02, KIND_HEADER, 16'd0, ST_MODIFIER, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'h00, KIND_HEADER, 16'd2, ST_MODIFIER, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'h00, KIND_HEADER, 16'd2, ST_MODIFIER, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'hAA, KIND_DISCARD, 16'd2, ST_MODIFIER, 1'b0));
    dir_rows.insert(dir_rows.size(), typed_row(8'hBB, KIND_DISCARD, 16'd2, ST_MODIFIER, 1'b1));
    // one-byte key, empty value, then an overrunning key length
    dir_rows.insert(dir_rows.size(), open_row(8'h00));
    dir_rows.insert(dir_rows.size(), open_row(8'h08));
    dir_rows.insert(dir_rows.size(), open_row(8'h00));
    dir_rows.insert(dir_rows.size(), open_row(8'h5A));
    dir_rows.insert(dir_rows.size(), open_row(8'h01));
    dir_rows.insert(dir_rows.size(), open_row(8'h00));
    dir_rows.insert(dir_rows.size(), open_row(8'h6B));
    dir_rows.insert(dir_rows.size(), open_row(8'h00));
    dir_rows.insert(dir_rows.size(), open_row(8'h00));
    dir_rows.insert(dir_rows.size(), open_row(8'hFF));
    dir_rows.insert(dir_rows.size(), open_row(8'hFF));
    dir_rows.insert(dir_rows.size(), open_row(8'h3C));
    // key length cut off by a one-byte block
    dir_rows.insert(dir_rows.size(), open_row(8'h00));
    dir_rows.insert(dir_rows.size(), open_row(8'h01));
    dir_rows.insert(dir_rows.size(), open_row(8'h00));
    dir_rows.insert(dir_rows.size(), open_row(8'hC3));
    dir_rows.insert(dir_rows.size(), typed_row(8'h7F, KIND_KLEN, 16'd1, ST_OVERRUN, 1'b1));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      want = deframe_byte(dir_rows[i].data_byte);
      if (dir_rows[i].typed) want = dir_rows[i].want;
      send_item(dir_rows[i].data_byte, want, 1'b0);
    end
    drain();

    // random packets under several modifier settings, extremes included
    settings[0] = 8'hFF;
    settings[1] = 8'h00;
    settings[2] = 8'($urandom_range(1, 254));
    settings[3] = 8'($urandom_range(0, 255));
    foreach (settings[s]) begin
      write_modifier(settings[s]);
      target = items_sent + ITEMS_PER_SETTING;
      while (items_sent < target) begin
        make_packet();
        calm = ($urandom_range(0, 3) == 0);
        foreach (pkt[i]) send_item(pkt[i], deframe_byte(pkt[i]), calm);
      end
      drain();
    end

    if (results_due.size() != 0)
      note_mismatch("results never arrived", 16'(results_due.size()), 16'd0);
    if (mismatches == 0) begin
      $display("key_value_packet_deframer_top_test OK");
    end else begin
      $display("key_value_packet_deframer_top_test NOT OK");
    end
    $finish;
  end

endmodule

/* key_value_packet_deframer_top.f */
design/kvd_pkg.sv
design/kvd_core.sv
design/kvd_out_reg.sv
design/key_value_packet_deframer_top.sv
bench/key_value_packet_deframer_top_test.sv
